/* rtl/capped_cylinder_sdf_macros.svh */
// ----------------------------------------------------------------------------
// Capped cylinder SDF assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef CAPPED_CYLINDER_SDF_MACROS_SVH
`define CAPPED_CYLINDER_SDF_MACROS_SVH

// checked only outside reset
`define CCS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CCS_ASSERT_ALL(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg
// Register map and fixed constants of the capped cylinder SDF block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  localparam int CFG_IDX_BITS = 3;

  // 1.0 in Q12.12
  localparam int unsigned UNIT_ONE = 4096;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_Z_BOTTOM = 3'd3,
    REG_Z_TOP    = 3'd4,
    REG_INVERT   = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/ccs_if.sv */
// ----------------------------------------------------------------------------
// ccs_if
// Valid/ready channels: query points in, distance results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_query_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;

  modport source (output valid, output px, output py, output pz, input ready);
  modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

interface ccs_result_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] distance;
  logic                         inside_res;

  modport source (output valid, output distance, output inside_res, input ready);
  modport sink   (input valid, input distance, input inside_res, output ready);
endinterface

`default_nettype wire

/* rtl/ccs_front.sv */
// ----------------------------------------------------------------------------
// ccs_front
// Offsets from the axis, magnitudes, squares and their sum; slab term.
// Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_front #(
  parameter int COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] z_bottom,
  input  logic signed [COORD_BITS-1:0] z_top,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2*COORD_BITS+1:0]      rad_sq,
  output logic signed [COORD_BITS:0]   slab
);

  localparam int N = COORD_BITS;
  localparam int D = N + 1;
  localparam int W = 2 * D;

  logic va, vb, vc, vd;
  logic en_a, en_b, en_c, en_d;

  logic signed [D-1:0] dx, dy, above, below;
  logic [D-1:0]        mx, my;
  logic signed [D-1:0] slab_b, slab_c, slab_d;
  logic [W-1:0]        sqx, sqy, sum;

  assign en_d     = !vd || out_ready;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      dx    <= {px[N-1], px} - {center_x[N-1], center_x};
      dy    <= {py[N-1], py} - {center_y[N-1], center_y};
      above <= {pz[N-1], pz} - {z_top[N-1], z_top};
      below <= {z_bottom[N-1], z_bottom} - {pz[N-1], pz};
    end
    if (en_b) begin
      mx     <= dx[D-1] ? (~dx + 1'b1) : dx;
      my     <= dy[D-1] ? (~dy + 1'b1) : dy;
      slab_b <= (above > below) ? above : below;
    end
    if (en_c) begin
      sqx    <= mx * mx;
      sqy    <= my * my;
      slab_c <= slab_b;
    end
    if (en_d) begin
      sum    <= sqx + sqy;
      slab_d <= slab_c;
    end
  end

  assign out_valid = vd;
  assign rad_sq    = sum;
  assign slab      = slab_d;

endmodule

`default_nettype wire

/* rtl/ccs_sqrt.sv */
// ----------------------------------------------------------------------------
// ccs_sqrt
// Pipelined integer square root, one result bit per stage, restoring form.
// The slab term rides alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_sqrt #(
  parameter int COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2*COORD_BITS+1:0]      rad_sq,
  input  logic signed [COORD_BITS:0]   slab_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_BITS:0]          root,
  output logic signed [COORD_BITS:0]   slab_out
);

  localparam int R  = COORD_BITS + 1;
  localparam int W  = 2 * R;
  localparam int RM = R + 2;

  logic                v       [R];
  logic [RM-1:0]       rem_q   [R];
  logic [R-1:0]        root_q  [R];
  logic [W-1:0]        rad_q   [R];
  logic signed [R-1:0] slab_q  [R];
  wire  [R-1:0]        en;

  for (genvar i = 0; i < R; i++) begin : g_stage
    logic                pv;
    logic [RM-1:0]       prem;
    logic [R-1:0]        proot;
    logic [W-1:0]        prad;
    logic signed [R-1:0] pslab;
    logic [RM+1:0]       cur, trial, diff;
    logic                ge;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = rad_sq;
      assign pslab = slab_in;
    end else begin : g_next
      assign pv    = v[i-1];
      assign prem  = rem_q[i-1];
      assign proot = root_q[i-1];
      assign prad  = rad_q[i-1];
      assign pslab = slab_q[i-1];
    end

    if (i == R - 1) begin : g_last
      assign en[i] = !v[i] || out_ready;
    end else begin : g_mid
      assign en[i] = !v[i] || en[i+1];
    end

    assign cur   = {prem, prad[W-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem_q[i]  <= ge ? diff[RM-1:0] : cur[RM-1:0];
        root_q[i] <= {proot[R-2:0], ge};
        rad_q[i]  <= prad << 2;
        slab_q[i] <= pslab;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[R-1];
  assign root      = root_q[R-1];
  assign slab_out  = slab_q[R-1];

endmodule

`default_nettype wire

/* rtl/ccs_back.sv */
// ----------------------------------------------------------------------------
// ccs_back
// Radial minus radius, max with slab, optional negation, saturation.
// The second stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_back #(
  parameter int COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COORD_BITS:0]          root,
  input  logic signed [COORD_BITS:0]   slab,
  input  logic [COORD_BITS-2:0]        cyl_radius,
  input  logic                         invert,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS+1:0] distance,
  output logic                         inside_res
);

  localparam int N = COORD_BITS;
  localparam int D = N + 1;
  localparam int E = N + 3;

  localparam logic signed [E-1:0] SAT_HI = {2'b00, {(N+1){1'b1}}};
  localparam logic signed [E-1:0] SAT_LO = {2'b11, {(N+1){1'b0}}};

  logic v1, v2, en1, en2;
  logic signed [E-1:0] radial, slab_e, sd, neg, sat;
  logic signed [N+1:0] dist_q;
  logic                inside_q;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign radial = {2'b00, root} - {4'b0000, cyl_radius};
  assign slab_e = {{2{slab[D-1]}}, slab};

  assign neg = invert ? -sd : sd;

  always_comb begin
    if (neg > SAT_HI) begin
      sat = SAT_HI;
    end else if (neg < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sd <= (radial > slab_e) ? radial : slab_e;
    end
    if (en2) begin
      dist_q   <= sat[N+1:0];
      inside_q <= sat[E-1];
    end
  end

  assign out_valid  = v2;
  assign distance   = dist_q;
  assign inside_res = inside_q;

endmodule

`default_nettype wire

/* rtl/capped_cylinder_sdf.sv */
// ----------------------------------------------------------------------------
// capped_cylinder_sdf
// Signed distance bound from a query point to a z-aligned capped cylinder.
//
// Query points (px, py, pz, signed Q12.12) arrive on the query channel and
// one result (distance, inside_res) leaves on the result channel per point,
// in order. Both channels are valid/ready; a request moves when both are high.
// Four front stages, one square root stage per result bit (COORD_BITS + 1),
// two back stages. Throughput is one point per cycle unless the result side
// stalls; every stage holds its own valid bit, so bubbles close up and a new
// point enters while a result waits. When the result receiver stalls, stages
// fill up behind the output register and query ready drops only once the pipe
// is full; nothing is lost. Configuration is written through wr_en /
// wr_index / wr_data, one register per cycle; the user must write it only
// while no point is in flight, which the block does not check. Unused indexes
// are ignored. Reset empties the pipe and returns the registers to a unit
// cylinder: centre 0, radius 1.0, caps at -1.0 and +1.0, no inversion.
// ----------------------------------------------------------------------------
`default_nettype none

module capped_cylinder_sdf
  import ccs_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  ccs_query_if.sink               query,
  ccs_result_if.source            result,
  input  logic                    wr_en,
  input  logic [CFG_IDX_BITS-1:0] wr_index,
  input  logic [COORD_BITS-1:0]   wr_data
);

  localparam int N = COORD_BITS;
  localparam logic [N-1:0] ONE = N'(UNIT_ONE);

  logic signed [N-1:0] center_x, center_y, z_bottom, z_top;
  logic [N-2:0]        cyl_radius;
  logic                invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      cyl_radius <= ONE[N-2:0];
      z_bottom   <= -ONE;
      z_top      <= ONE;
      invert     <= 1'b0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_CENTER_X: center_x   <= wr_data;
        REG_CENTER_Y: center_y   <= wr_data;
        REG_RADIUS:   cyl_radius <= wr_data[N-2:0];
        REG_Z_BOTTOM: z_bottom   <= wr_data;
        REG_Z_TOP:    z_top      <= wr_data;
        REG_INVERT:   invert     <= wr_data[0];
        default: ;
      endcase
    end
  end

  logic                f_valid, f_ready, s_valid, s_ready;
  logic [2*N+1:0]      rad_sq;
  logic signed [N:0]   f_slab, s_slab;
  logic [N:0]          root;

  ccs_front #(.COORD_BITS(N)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (query.valid),
    .in_ready (query.ready),
    .px       (query.px),
    .py       (query.py),
    .pz       (query.pz),
    .center_x (center_x),
    .center_y (center_y),
    .z_bottom (z_bottom),
    .z_top    (z_top),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .rad_sq   (rad_sq),
    .slab     (f_slab)
  );

  ccs_sqrt #(.COORD_BITS(N)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .rad_sq   (rad_sq),
    .slab_in  (f_slab),
    .out_valid(s_valid),
    .out_ready(s_ready),
    .root     (root),
    .slab_out (s_slab)
  );

  ccs_back #(.COORD_BITS(N)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .root      (root),
    .slab      (s_slab),
    .cyl_radius(cyl_radius),
    .invert    (invert),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .distance  (result.distance),
    .inside_res(result.inside_res)
  );

endmodule

`default_nettype wire

/* rtl/ccs_checker.sv */
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks on the result channel of capped_cylinder_sdf.
// ----------------------------------------------------------------------------
`default_nettype none

`include "capped_cylinder_sdf_macros.svh"

module ccs_checker #(
  parameter int COORD_BITS
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS+1:0] distance,
  input logic                         inside_res
);

  `CCS_ASSERT_ALL(a_empty_after_reset, clk, $past(rst) |-> !out_valid, "result valid after reset")
  `CCS_ASSERT(a_inside_sign, clk, rst, out_valid |-> (inside_res == distance[COORD_BITS+1]), "inside flag disagrees with sign")
  `CCS_ASSERT(a_valid_held, clk, rst, out_valid && !out_ready |=> out_valid, "stalled result dropped")
  `CCS_ASSERT(a_payload_held, clk, rst, out_valid && !out_ready |=> $stable(distance) && $stable(inside_res), "stalled result changed")

endmodule

bind capped_cylinder_sdf ccs_checker #(.COORD_BITS(COORD_BITS)) u_ccs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .distance  (result.distance),
  .inside_res(result.inside_res)
);

`default_nettype wire
